@@ rtl/sam_pkg.sv @@
// Package for the suffix automaton builder: sizes, status codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
package sam_pkg;
    localparam int MAX_LEN     = 512;
    localparam int SYMBOL_BITS = 8;
    localparam int NUM_STATES  = 2 * MAX_LEN;
    localparam int NUM_SYMS    = 1 << SYMBOL_BITS;
    localparam int SW          = $clog2(NUM_STATES);
    localparam int TW          = SW + SYMBOL_BITS;
    localparam int CW          = 18;
    localparam int LSW         = 25;

    localparam logic [1:0] ST_APPENDED  = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_RESTARTED = 2'd2;

    typedef logic [SW-1:0] t_state;
endpackage

@@ rtl/suffix_automaton_builder.sv @@
// Online suffix automaton builder; depends on sam_pkg and sam_ram. One word in flight.
// Steps from acceptance to the result: a full reject goes straight to the output; a restart
// gives its result, then clears the root row; an append clears the new row, walks the link
// chain, tests an existing edge and on a clone copies its row and redirects the old edges.
// Reset (synchronous, active low) clears the root row with busy high.
// The receiver cannot stall: o_valid is high one cycle per word.
`timescale 1ns / 1ps
module suffix_automaton_builder (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_action,
    input  logic [7:0]                i_symbol,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic [sam_pkg::CW-1:0]    o_distinct_count,
    output logic [sam_pkg::LSW-1:0]   o_distinct_length_sum,
    output logic [sam_pkg::SW:0]      o_states_used
);
    import sam_pkg::*;

    typedef enum logic [13:0] {
        S_CLR    = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_NCLR   = 14'b00000000000100,
        S_WRD    = 14'b00000000001000,
        S_WCHK   = 14'b00000000010000,
        S_LNK    = 14'b00000000100000,
        S_QRD    = 14'b00000001000000,
        S_QCHK   = 14'b00000010000000,
        S_CPRD   = 14'b00000100000000,
        S_CPWR   = 14'b00001000000000,
        S_RRD    = 14'b00010000000000,
        S_RCHK   = 14'b00100000000000,
        S_TOT    = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } t_fsm;

    t_fsm r_st, n_st;
    logic [SYMBOL_BITS-1:0] r_c, n_c, r_k, n_k;
    t_state r_last, n_last, r_cur, n_cur, r_p, n_p, r_q, n_q, r_cl, n_cl;
    logic [SW:0] r_cnt, n_cnt;
    logic [CW-1:0] r_rc, n_rc;
    logic [LSW-1:0] r_rs, n_rs;
    logic [1:0] r_stat, n_stat;
    logic [SW-1:0] r_ln, n_ln;   // len(link(cur))
    logic [SW-1:0] r_lc, n_lc;   // len(cur)
    logic [SW-1:0] r_lp, n_lp;   // len(p)

    // memories
    logic tr_we, l_we, k_we;
    logic [TW-1:0] tr_wa, tr_ra;
    t_state tr_wd, tr_rd;
    t_state l_wa, l_ra, k_wa, k_ra;
    logic [SW-1:0] l_wd, l_rd;
    t_state k_wd, k_rd;

    sam_ram #(.AW(TW), .DW(SW)) u_tr (.i_clk, .i_we(tr_we), .i_waddr(tr_wa),
        .i_wdata(tr_wd), .i_raddr(tr_ra), .o_rdata(tr_rd));
    sam_ram #(.AW(SW), .DW(SW)) u_len (.i_clk, .i_we(l_we), .i_waddr(l_wa),
        .i_wdata(l_wd), .i_raddr(l_ra), .o_rdata(l_rd));
    sam_ram #(.AW(SW), .DW(SW)) u_lnk (.i_clk, .i_we(k_we), .i_waddr(k_wa),
        .i_wdata(k_wd), .i_raddr(k_ra), .o_rdata(k_rd));

    logic [2*SW:0] w_tri;
    assign busy = (r_st != S_IDLE);

    // sequencer
    always_comb begin
        n_st = r_st; n_c = r_c; n_k = r_k; n_last = r_last; n_cur = r_cur;
        n_p = r_p; n_q = r_q; n_cl = r_cl; n_cnt = r_cnt; n_rc = r_rc;
        n_rs = r_rs; n_stat = r_stat; n_ln = r_ln;
        n_lc = r_lc; n_lp = r_lp;
        tr_we = 1'b0; tr_wa = '0; tr_wd = '0; tr_ra = '0;
        l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
        k_we = 1'b0; k_wa = '0; k_wd = '0; k_ra = '0;
        w_tri = '0;
        o_valid = 1'b0;
        case (r_st)
            S_CLR: begin
                tr_we = 1'b1; tr_wa = {t_state'(0), r_k}; l_we = 1'b1;
                k_we = 1'b1;
                n_k = r_k + 1'b1;
                if (r_k == SYMBOL_BITS'(NUM_SYMS-1)) n_st = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_c = i_symbol[SYMBOL_BITS-1:0];
                    n_k = '0;
                    if (i_action) begin
                        n_cnt = (SW+1)'(1); n_rc = '0; n_rs = '0;
                        n_last = '0; n_stat = ST_RESTARTED;
                        n_st = S_OUT;
                    end else if (r_lc >= SW'(MAX_LEN) ||
                                 r_cnt + 2'd2 > (SW+1)'(NUM_STATES)) begin
                        n_stat = ST_FULL; n_st = S_OUT;
                    end else begin
                        n_cur = r_cnt[SW-1:0]; n_cnt = r_cnt + 1'b1;
                        n_p = r_last; n_lp = r_lc; n_lc = r_lc + 1'b1;
                        n_stat = ST_APPENDED;
                        n_st = S_NCLR;
                    end
                end
            end
            S_NCLR: begin
                tr_we = 1'b1; tr_wa = {r_cur, r_k};
                n_k = r_k + 1'b1;
                if (r_k == SYMBOL_BITS'(NUM_SYMS-1)) begin
                    l_we = 1'b1; l_wa = r_cur; l_wd = r_lc;
                    n_st = S_WRD;
                end
            end
            // walk: read trans[p][c], len(p), link(p)
            S_WRD: begin
                tr_ra = {r_p, r_c}; l_ra = r_p; k_ra = r_p;
                n_st = S_WCHK;
            end
            S_WCHK: begin
                n_lp = l_rd;
                if (tr_rd != '0) begin
                    n_q = tr_rd; n_st = S_QRD;
                end else begin
                    tr_we = 1'b1; tr_wa = {r_p, r_c}; tr_wd = r_cur;
                    if (r_p == '0) begin
                        n_ln = '0;
                        k_we = 1'b1; k_wa = r_cur; k_wd = '0;
                        n_st = S_TOT;
                    end else begin
                        n_p = k_rd; n_st = S_WRD;
                    end
                end
            end
            S_QRD: begin
                l_ra = r_q; k_ra = r_q; n_st = S_QCHK;
            end
            S_QCHK: begin
                if (l_rd == r_lp + 1'b1) begin
                    k_we = 1'b1; k_wa = r_cur; k_wd = r_q; n_ln = l_rd;
                    n_st = S_TOT;
                end else begin
                    n_cl = r_cnt[SW-1:0]; n_cnt = r_cnt + 1'b1;
                    l_we = 1'b1; l_wa = r_cnt[SW-1:0]; l_wd = r_lp + 1'b1;
                    k_we = 1'b1; k_wa = r_cnt[SW-1:0]; k_wd = k_rd;
                    n_ln = r_lp + 1'b1; n_k = '0;
                    n_st = S_CPRD;
                end
            end
            S_CPRD: begin
                tr_ra = {r_q, r_k}; n_st = S_CPWR;
                if (r_k == '0) begin
                    k_we = 1'b1; k_wa = r_q; k_wd = r_cl;
                end
            end
            S_CPWR: begin
                tr_we = 1'b1; tr_wa = {r_cl, r_k}; tr_wd = tr_rd;
                n_k = r_k + 1'b1;
                if (r_k == SYMBOL_BITS'(NUM_SYMS-1)) begin
                    k_we = 1'b1; k_wa = r_cur; k_wd = r_cl;
                    n_st = S_RRD;
                end else n_st = S_CPRD;
            end
            S_RRD: begin
                tr_ra = {r_p, r_c}; k_ra = r_p; n_st = S_RCHK;
            end
            S_RCHK: begin
                if (tr_rd != r_q) n_st = S_TOT;
                else begin
                    tr_we = 1'b1; tr_wa = {r_p, r_c}; tr_wd = r_cl;
                    if (r_p == '0) n_st = S_TOT;
                    else begin n_p = k_rd; n_st = S_RRD; end
                end
            end
            S_TOT: begin
                // counts: len(cur) - len(link), tri difference
                n_rc = r_rc + CW'(r_lc) - CW'(r_ln);
                w_tri = ((2*SW+1)'(r_lc) * (2*SW+1)'(r_lc + 1'b1)) -
                        ((2*SW+1)'(r_ln) * (2*SW+1)'(r_ln + 1'b1));
                n_rs = r_rs + LSW'(w_tri >> 1);
                n_last = r_cur;
                n_st = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                n_k = '0;
                n_st = (r_stat == ST_RESTARTED) ? S_CLR : S_IDLE;
                if (r_stat == ST_RESTARTED) n_lc = '0;
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_status = r_stat;
    assign o_distinct_count = r_rc;
    assign o_distinct_length_sum = r_rs;
    assign o_states_used = r_cnt;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_k <= '0; r_last <= '0; r_cnt <= (SW+1)'(1);
            r_rc <= '0; r_rs <= '0; r_lc <= '0; r_stat <= ST_APPENDED;
        end else begin
            r_st <= n_st; r_k <= n_k; r_last <= n_last; r_cnt <= n_cnt;
            r_rc <= n_rc; r_rs <= n_rs; r_lc <= n_lc; r_stat <= n_stat;
        end
        r_c <= n_c; r_cur <= n_cur; r_p <= n_p; r_q <= n_q; r_cl <= n_cl;
        r_ln <= n_ln; r_lp <= n_lp;
    end
endmodule

@@ rtl/sam_ram.sv @@
// Generic single-port-write, single-read synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module sam_ram #(
    parameter int AW = 10,
    parameter int DW = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [(1<<AW)];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
